// ===== rtl/core/tbl_pkg.sv =====
// Shared widths, register indexes and status types of the token bucket limiter.
package tbl_pkg;

	localparam int CAP_W     = 48;
	localparam int RATE_W    = 32;
	localparam int RETRY_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int MUL_W     = CAP_W / 2;
	localparam int PROD_W    = CAP_W + RATE_W;
	localparam int DIV_CNT_W = $clog2(CAP_W);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = CFG_IDX_W'(1);

	localparam logic [RETRY_W-1:0] RETRY_MAX = {RETRY_W{1'b1}};

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CAP_W-1:0]     data;
	} tbl_cfg_wr_t;

	typedef struct packed {
		logic valid;
		logic peek;
	} tbl_qstat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tbl_div_stat_t;

endpackage

// ===== rtl/core/tbl_if.sv =====
// Request and result channel interfaces of the token bucket limiter.
interface tbl_req_if import tbl_pkg::*; #(parameter int TIME_WIDTH = 32) ();
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] now_tick;
	logic [CAP_W-1:0]      cost;

	modport source (output valid, output now_tick, output cost, input ready);
	modport sink (input valid, input now_tick, input cost, output ready);
endinterface

interface tbl_res_if import tbl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               allowed;
	logic [CAP_W-1:0]   tokens_left;
	logic [RETRY_W-1:0] retry_ticks;

	modport source (output valid, output allowed, output tokens_left, output retry_ticks,
		input ready);
	modport sink (input valid, input allowed, input tokens_left, input retry_ticks,
		output ready);
endinterface

// ===== rtl/core/tbl_front.sv =====
// Request front end: accepts transactions into a two-entry queue and flags peeks.
module tbl_front import tbl_pkg::*; #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tbl_req_if.sink               req,
	input  logic                  item_pop,
	output tbl_qstat_t            qstat,
	output logic [TIME_WIDTH-1:0] item_now,
	output logic [CAP_W-1:0]      item_cost
);

	logic [TIME_WIDTH-1:0] now_q  [QDEPTH];
	logic [CAP_W-1:0]      cost_q [QDEPTH];
	logic                  peek_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  push;
	logic                  pop;

	assign req.ready = (count_q != QCNT_W'(QDEPTH));
	assign push      = req.valid & req.ready;
	assign pop       = item_pop & (count_q != '0);

	// The queue depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			now_q[wr_ptr_q]  <= req.now_tick;
			cost_q[wr_ptr_q] <= req.cost;
			peek_q[wr_ptr_q] <= (req.cost == '0);
		end
	end

	assign qstat.valid = (count_q != '0);
	assign qstat.peek  = peek_q[rd_ptr_q];
	assign item_now    = now_q[rd_ptr_q];
	assign item_cost   = cost_q[rd_ptr_q];

endmodule

// ===== rtl/core/tbl_div.sv =====
// Bit-serial divider that returns the saturated ceiling of the quotient.
module tbl_div import tbl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CAP_W-1:0]   dividend,
	input  logic [RATE_W-1:0]  divisor,
	output tbl_div_stat_t      stat,
	output logic [RETRY_W-1:0] result
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RATE_W-1:0]    rem_q;
	logic [CAP_W-1:0]     quo_q;
	logic [RATE_W-1:0]    divisor_q;
	logic [RATE_W:0]      trial;
	logic                 fits;
	logic [CAP_W:0]       quo_ceil;

	assign trial = {rem_q, quo_q[CAP_W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(CAP_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? RATE_W'(trial - {1'b0, divisor_q}) : trial[RATE_W-1:0];
			quo_q <= {quo_q[CAP_W-2:0], fits};
		end
	end

	// A nonzero remainder rounds the quotient up before saturation.
	assign quo_ceil = {1'b0, quo_q} + (CAP_W + 1)'(rem_q != '0);
	assign result   = (|quo_ceil[CAP_W:RETRY_W]) ? RETRY_MAX : quo_ceil[RETRY_W-1:0];

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/core/tbl_back.sv =====
// Bucket engine: refill, admission decision, retry computation and result register.
module tbl_back import tbl_pkg::*; #(
	parameter int TIME_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbl_cfg_wr_t           cfg,
	input  tbl_qstat_t            qstat,
	input  logic [TIME_WIDTH-1:0] item_now,
	input  logic [CAP_W-1:0]      item_cost,
	output logic                  item_pop,
	tbl_res_if.source             res
);

	localparam logic [CAP_W-1:0]  CAP_RST  = CAP_W'(64'd10 << FRAC_BITS);
	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(64'd1 << FRAC_BITS);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL_LO = 8'b0000_0010,
		S_MUL_HI = 8'b0000_0100,
		S_ADD    = 8'b0000_1000,
		S_REFILL = 8'b0001_0000,
		S_DECIDE = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [RATE_W-1:0]     rate_q;
	logic [CAP_W-1:0]      level_q;
	logic [TIME_WIDTH-1:0] last_q;

	logic [TIME_WIDTH-1:0] now_q;
	logic [CAP_W-1:0]      cost_q;
	logic                  peek_q;
	logic                  later_q;
	logic                  esat_q;
	logic [CAP_W-1:0]      elapsed_q;
	logic [CAP_W-1:0]      room_q;
	logic [MUL_W+RATE_W-1:0] plo_q;
	logic [MUL_W+RATE_W-1:0] phi_q;
	logic [PROD_W-1:0]     prod_q;

	logic                  res_allowed_q;
	logic [CAP_W-1:0]      res_tokens_q;
	logic [RETRY_W-1:0]    res_retry_q;
	logic                  out_valid_q;
	logic                  out_allowed_q;
	logic [CAP_W-1:0]      out_tokens_q;
	logic [RETRY_W-1:0]    out_retry_q;

	logic [TIME_WIDTH-1:0] elapsed;
	logic [63:0]           elapsed_ext;
	logic                  overflow;
	logic                  covers;
	logic                  div_start;
	logic [CAP_W-1:0]      shortfall;
	tbl_div_stat_t         div_stat;
	logic [RETRY_W-1:0]    div_result;
	logic                  out_free;

	assign elapsed     = item_now - last_q;
	assign elapsed_ext = 64'(elapsed);
	assign overflow    = esat_q || (|prod_q[PROD_W-1:CAP_W]) || (prod_q[CAP_W-1:0] > room_q);
	assign covers      = peek_q || (level_q >= cost_q);
	assign shortfall   = cost_q - level_q;
	assign div_start   = (state_q == S_DECIDE) && !covers && (rate_q != '0);
	assign out_free    = !out_valid_q || res.ready;
	assign item_pop    = (state_q == S_IDLE) && qstat.valid;

	tbl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (shortfall),
		.divisor  (rate_q),
		.stat     (div_stat),
		.result   (div_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RST;
			rate_q      <= RATE_RST;
			level_q     <= CAP_RST;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (qstat.valid) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ADD;
				S_ADD:    state_q <= S_REFILL;
				S_REFILL: begin
					if (later_q) begin
						last_q <= now_q;
						if (rate_q != '0) begin
							level_q <= overflow ? cap_q : level_q + prod_q[CAP_W-1:0];
						end
					end
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (covers) begin
						level_q <= level_q - cost_q;
					end
					state_q <= div_start ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg.we) begin
				case (cfg.index)
					CFG_CAPACITY: begin
						cap_q   <= cfg.data;
						level_q <= cfg.data;
					end
					CFG_REFILL_RATE: rate_q <= cfg.data[RATE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_q     <= item_now;
				cost_q    <= item_cost;
				peek_q    <= qstat.peek;
				later_q   <= (item_now > last_q);
				esat_q    <= |elapsed_ext[63:CAP_W];
				elapsed_q <= elapsed_ext[CAP_W-1:0];
				room_q    <= (level_q < cap_q) ? cap_q - level_q : '0;
			end
			S_MUL_LO: plo_q <= elapsed_q[MUL_W-1:0] * rate_q;
			S_MUL_HI: phi_q <= elapsed_q[CAP_W-1:MUL_W] * rate_q;
			S_ADD:    prod_q <= PROD_W'(plo_q) + {phi_q, {MUL_W{1'b0}}};
			S_DECIDE: begin
				res_allowed_q <= covers;
				res_tokens_q  <= covers ? level_q - cost_q : level_q;
				res_retry_q   <= covers ? '0 : RETRY_MAX;
			end
			S_DIV: begin
				if (div_stat.done) begin
					res_retry_q <= div_result;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_allowed_q <= res_allowed_q;
					out_tokens_q  <= res_tokens_q;
					out_retry_q   <= res_retry_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid       = out_valid_q;
	assign res.allowed     = out_allowed_q;
	assign res.tokens_left = out_tokens_q;
	assign res.retry_ticks = out_retry_q;

endmodule

// ===== rtl/core/token_bucket_limiter.sv =====
// Top level of the token bucket limiter: request queue, bucket engine and configuration port.
//
// Each request refills the bucket by the ticks elapsed since the last refill times the refill
// rate, saturating at capacity, then is admitted and charged if the bucket covers its cost.
// A two-entry queue takes requests while the engine works. The engine handles one request at a
// time: an admitted request, or any request while the refill rate is zero, passes from the head
// of the queue to the result register through operand capture, two partial products, sum,
// refill, decision and result. A denied request with a nonzero refill rate also runs the
// bit-serial divider that forms the retry time, one quotient bit per cycle over the 48-bit
// shortfall. Results wait in an output register, so the engine stalls only when that register
// is still full. The user must write configuration through cfg_we, cfg_index and cfg_data only
// while no request is pending; the block does not enforce this. A capacity write also fills the bucket.
module token_bucket_limiter import tbl_pkg::*; #(
	parameter int FRAC_BITS  = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	tbl_req_if.sink              req,
	tbl_res_if.source            res
);

	tbl_cfg_wr_t           cfg;
	tbl_qstat_t            qstat;
	logic [TIME_WIDTH-1:0] item_now;
	logic [CAP_W-1:0]      item_cost;
	logic                  item_pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	tbl_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.item_pop  (item_pop),
		.qstat     (qstat),
		.item_now  (item_now),
		.item_cost (item_cost)
	);

	tbl_back #(
		.TIME_WIDTH (TIME_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.qstat     (qstat),
		.item_now  (item_now),
		.item_cost (item_cost),
		.item_pop  (item_pop),
		.res       (res)
	);

`ifndef SYNTHESIS
	// The engine takes a transaction from the queue only when one is there.
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> qstat.valid)
		else $error("engine popped an empty queue");

	// The engine finishes one transaction before it takes the next.
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> !item_pop)
		else $error("engine popped on consecutive cycles");

	// A full queue holds a transaction for the engine.
	a_full_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> qstat.valid)
		else $error("queue refuses requests while empty");
`endif

endmodule
